[rtl/core/dhtr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhtr_pkg: shared types and constants for the sensor frame receiver
// Command, status and register codes, field widths and register defaults.
// ----------------------------------------------------------------------------
package dhtr_pkg;

  localparam int FRAME_BYTES = 5;
  localparam int FRAME_W     = 8 * FRAME_BYTES;
  localparam int BITS_W      = $clog2(FRAME_W + 1);
  localparam int US_W        = 16;
  localparam int WIN_W       = 10;
  localparam int READ_W      = 16;
  localparam int STATUS_W    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WIN_W-1:0] GLITCH_US = WIN_W'(10);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_EDGE  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_ACQUIRING   = 4'd1,
    ST_BUSY        = 4'd2,
    ST_TIMEOUT     = 4'd3,
    ST_RESP_ERR    = 4'd4,
    ST_CHECKSUM    = 4'd5,
    ST_GLITCH      = 4'd6,
    ST_DATA_ERR    = 4'd7,
    ST_NOT_STARTED = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_TYPE   = 3'd0,
    REG_EDGE_TIMEOUT  = 3'd1,
    REG_PREAMBLE_MAX  = 3'd2,
    REG_RESPONSE_MIN  = 3'd3,
    REG_RESPONSE_MAX  = 3'd4,
    REG_BIT_MIN       = 3'd5,
    REG_BIT_MAX       = 3'd6,
    REG_ONE_THRESHOLD = 3'd7
  } cfg_reg_t;

  localparam logic             RST_SENSOR_TYPE   = 1'b1;
  localparam logic [US_W-1:0]  RST_EDGE_TIMEOUT  = US_W'(6000);
  localparam logic [WIN_W-1:0] RST_PREAMBLE_MAX  = WIN_W'(65);
  localparam logic [WIN_W-1:0] RST_RESPONSE_MIN  = WIN_W'(125);
  localparam logic [WIN_W-1:0] RST_RESPONSE_MAX  = WIN_W'(200);
  localparam logic [WIN_W-1:0] RST_BIT_MIN       = WIN_W'(60);
  localparam logic [WIN_W-1:0] RST_BIT_MAX       = WIN_W'(155);
  localparam logic [WIN_W-1:0] RST_ONE_THRESHOLD = WIN_W'(110);

endpackage
`default_nettype wire

[rtl/core/dhtr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhtr_in_if / dhtr_out_if: valid-ready channels of the frame receiver
// Edge and command transactions in, status and reading transactions out.
// ----------------------------------------------------------------------------
interface dhtr_in_if;
  import dhtr_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [US_W-1:0]   elapsed_us;

  modport source (output valid, command, elapsed_us, input ready);
  modport sink   (input valid, command, elapsed_us, output ready);
endinterface

interface dhtr_out_if;
  import dhtr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     done_res;
  logic [READ_W-1:0]        humidity_tenths;
  logic signed [READ_W-1:0] temperature_tenths;

  modport source (output valid, status, done_res, humidity_tenths, temperature_tenths,
                  input ready);
  modport sink   (input valid, status, done_res, humidity_tenths, temperature_tenths,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/dht_edge_timing_receiver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_edge_timing_receiver: single-wire humidity/temperature frame receiver
// Decodes a sensor frame from falling-edge intervals into a reading.
// ----------------------------------------------------------------------------
// Every transaction in gives exactly one transaction out, in the cycle after
// it is taken. The block takes one transaction per clock while its results
// are taken: each edge or start is decoded by a single compare, shift and
// checksum step straight into the result register, and in_ch.ready is high
// whenever that register is empty or is being taken in the same cycle. Write
// the timing registers only while no result is pending.
module dht_edge_timing_receiver
  import dhtr_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  dhtr_in_if.sink                in_ch,
  dhtr_out_if.source             out_ch,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    PH_STOPPED  = 2'd0,
    PH_RESPONSE = 2'd1,
    PH_DATA     = 2'd2,
    PH_ACQUIRED = 2'd3
  } phase_t;

  logic             sensor_type_r;
  logic [US_W-1:0]  edge_timeout_r;
  logic [WIN_W-1:0] preamble_max_r;
  logic [WIN_W-1:0] response_min_r;
  logic [WIN_W-1:0] response_max_r;
  logic [WIN_W-1:0] bit_min_r;
  logic [WIN_W-1:0] bit_max_r;
  logic [WIN_W-1:0] one_threshold_r;

  phase_t              phase_r, phase_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic [WIN_W-1:0]    carried_r, carried_nxt;
  status_t             last_status_r, last_status_nxt;
  logic [READ_W-1:0]   hum_r, hum_nxt;
  logic [READ_W-1:0]   temp_r, temp_nxt;

  logic                out_valid_r;
  status_t             out_status_r, res_status;
  logic                out_done_r, res_done;
  logic [READ_W-1:0]   out_hum_r;
  logic [READ_W-1:0]   out_temp_r;

  logic                in_acc;
  logic                idle;
  logic [US_W:0]       delta;
  logic [FRAME_W-1:0]  frame_shifted;
  logic [BITS_W-1:0]   bits_inc;
  logic [7:0]          b0, b1, b2, b3, b4;
  logic [7:0]          sum;
  logic [READ_W-1:0]   conv_hum, conv_temp, mag;
  logic                bit_window;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign idle         = (phase_r == PH_STOPPED) || (phase_r == PH_ACQUIRED);
  assign delta        = {1'b0, in_ch.elapsed_us} + (US_W + 1)'(carried_r);
  assign bit_window   = ((US_W + 1)'(bit_min_r) < delta) && (delta < (US_W + 1)'(bit_max_r));
  assign frame_shifted = {frame_r[FRAME_W-2:0], delta > (US_W + 1)'(one_threshold_r)};
  assign bits_inc     = bits_r + BITS_W'(1);

  assign b0  = frame_shifted[FRAME_W-1  -: 8];
  assign b1  = frame_shifted[FRAME_W-9  -: 8];
  assign b2  = frame_shifted[FRAME_W-17 -: 8];
  assign b3  = frame_shifted[FRAME_W-25 -: 8];
  assign b4  = frame_shifted[FRAME_W-33 -: 8];
  assign sum = b0 + b1 + b2 + b3;
  assign mag = {1'b0, b2[6:0], b3};

  always_comb begin
    if (sensor_type_r == 1'b0) begin
      conv_hum  = READ_W'({b0, 3'b000}) + READ_W'({b0, 1'b0});
      conv_temp = READ_W'({b2, 3'b000}) + READ_W'({b2, 1'b0});
    end else begin
      conv_hum  = {b0, b1};
      conv_temp = b2[7] ? (READ_W'(0) - mag) : {b2, b3};
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    frame_nxt       = frame_r;
    bits_nxt        = bits_r;
    carried_nxt     = carried_r;
    last_status_nxt = last_status_r;
    hum_nxt         = hum_r;
    temp_nxt        = temp_r;
    res_status      = ST_ACQUIRING;
    res_done        = 1'b0;
    if (in_ch.command == CMD_START) begin
      if (idle) begin
        phase_nxt   = PH_RESPONSE;
        frame_nxt   = '0;
        bits_nxt    = '0;
        carried_nxt = '0;
      end else begin
        res_status = ST_BUSY;
      end
    end else if (idle) begin
      res_status = last_status_r;
    end else begin
      carried_nxt = '0;
      if (delta > (US_W + 1)'(edge_timeout_r)) begin
        res_status = ST_TIMEOUT;
        res_done   = 1'b1;
        phase_nxt  = PH_STOPPED;
      end else if (phase_r == PH_RESPONSE) begin
        if (delta < (US_W + 1)'(preamble_max_r)) begin
          carried_nxt = delta[WIN_W-1:0];
        end else if (((US_W + 1)'(response_min_r) < delta) &&
                     (delta < (US_W + 1)'(response_max_r))) begin
          phase_nxt = PH_DATA;
        end else begin
          res_status = ST_RESP_ERR;
          res_done   = 1'b1;
          phase_nxt  = PH_STOPPED;
        end
      end else if (bit_window) begin
        frame_nxt = frame_shifted;
        bits_nxt  = bits_inc;
        if (bits_inc == BITS_W'(FRAME_W)) begin
          res_done = 1'b1;
          if (sum != b4) begin
            res_status = ST_CHECKSUM;
            phase_nxt  = PH_STOPPED;
          end else begin
            res_status = ST_OK;
            phase_nxt  = PH_ACQUIRED;
            hum_nxt    = conv_hum;
            temp_nxt   = conv_temp;
          end
        end
      end else if (delta < (US_W + 1)'(GLITCH_US)) begin
        res_status = ST_GLITCH;
        res_done   = 1'b1;
        phase_nxt  = PH_STOPPED;
      end else begin
        res_status = ST_DATA_ERR;
        res_done   = 1'b1;
        phase_nxt  = PH_STOPPED;
      end
      if (res_done) begin
        last_status_nxt = res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r   <= RST_SENSOR_TYPE;
      edge_timeout_r  <= RST_EDGE_TIMEOUT;
      preamble_max_r  <= RST_PREAMBLE_MAX;
      response_min_r  <= RST_RESPONSE_MIN;
      response_max_r  <= RST_RESPONSE_MAX;
      bit_min_r       <= RST_BIT_MIN;
      bit_max_r       <= RST_BIT_MAX;
      one_threshold_r <= RST_ONE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENSOR_TYPE:   sensor_type_r   <= cfg_data[0];
        REG_EDGE_TIMEOUT:  edge_timeout_r  <= cfg_data[US_W-1:0];
        REG_PREAMBLE_MAX:  preamble_max_r  <= cfg_data[WIN_W-1:0];
        REG_RESPONSE_MIN:  response_min_r  <= cfg_data[WIN_W-1:0];
        REG_RESPONSE_MAX:  response_max_r  <= cfg_data[WIN_W-1:0];
        REG_BIT_MIN:       bit_min_r       <= cfg_data[WIN_W-1:0];
        REG_BIT_MAX:       bit_max_r       <= cfg_data[WIN_W-1:0];
        REG_ONE_THRESHOLD: one_threshold_r <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_STOPPED;
      frame_r       <= '0;
      bits_r        <= '0;
      carried_r     <= '0;
      last_status_r <= ST_NOT_STARTED;
      hum_r         <= '0;
      temp_r        <= '0;
      out_valid_r   <= 1'b0;
      out_status_r  <= ST_OK;
      out_done_r    <= 1'b0;
      out_hum_r     <= '0;
      out_temp_r    <= '0;
    end else begin
      if (in_acc) begin
        phase_r       <= phase_nxt;
        frame_r       <= frame_nxt;
        bits_r        <= bits_nxt;
        carried_r     <= carried_nxt;
        last_status_r <= last_status_nxt;
        hum_r         <= hum_nxt;
        temp_r        <= temp_nxt;
        out_valid_r   <= 1'b1;
        out_status_r  <= res_status;
        out_done_r    <= res_done;
        out_hum_r     <= (res_status == ST_OK) ? hum_nxt : '0;
        out_temp_r    <= (res_status == ST_OK) ? temp_nxt : '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.done_res           = out_done_r;
  assign out_ch.humidity_tenths    = out_hum_r;
  assign out_ch.temperature_tenths = out_temp_r;

`ifndef SYNTHESIS
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |->
      out_status_r != ST_ACQUIRING && out_status_r != ST_BUSY &&
      out_status_r != ST_NOT_STARTED)
    else $error("finishing transaction carries a non-final status");

  a_reading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_hum_r == '0 && out_temp_r == '0)
    else $error("reading fields set on a non-ok status");

  a_idle_edge: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.command == CMD_EDGE && idle |=> !out_done_r && $stable(phase_r))
    else $error("ignored edge changed phase or ended an acquisition");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty result register");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bits_r < BITS_W'(FRAME_W))
    else $error("bit count ran past the frame while in the data phase");
`endif

endmodule
`default_nettype wire

[test/dht_edge_timing_receiver_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhtr_reading_checker: result checker for the sensor frame receiver
// Watches the edge, result and register ports, decodes every accepted
// transaction with its own copy of the receiver state and compares each
// result transaction, field by field, with the oldest predicted reading.
// ----------------------------------------------------------------------------
module dhtr_reading_checker
  import dhtr_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  dhtr_in_if                   in_ch,
  dhtr_out_if                  out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   readings_due
);

  typedef enum logic [1:0] {
    RX_STOPPED  = 2'd0,
    RX_RESPONSE = 2'd1,
    RX_DATA     = 2'd2,
    RX_ACQUIRED = 2'd3
  } rx_phase_t;

  typedef struct packed {
    status_t                  status;
    logic                     done;
    logic [READ_W-1:0]        humidity;
    logic signed [READ_W-1:0] temperature;
  } reading_t;

  logic                     sensor_type;
  logic [US_W-1:0]          edge_timeout;
  logic [WIN_W-1:0]         preamble_max;
  logic [WIN_W-1:0]         response_min;
  logic [WIN_W-1:0]         response_max;
  logic [WIN_W-1:0]         bit_min;
  logic [WIN_W-1:0]         bit_max;
  logic [WIN_W-1:0]         one_threshold;

  rx_phase_t                rx_phase;
  logic [FRAME_W-1:0]       frame;
  logic [BITS_W-1:0]        bit_count;
  logic [US_W:0]            carried;
  status_t                  last_status;
  logic [READ_W-1:0]        last_hum;
  logic signed [READ_W-1:0] last_temp;

  reading_t expected_readings[$];

  initial begin
    mismatches   = 0;
    readings_due = 0;
  end

  function automatic void reset_receiver_model();
    sensor_type   = RST_SENSOR_TYPE;
    edge_timeout  = RST_EDGE_TIMEOUT;
    preamble_max  = RST_PREAMBLE_MAX;
    response_min  = RST_RESPONSE_MIN;
    response_max  = RST_RESPONSE_MAX;
    bit_min       = RST_BIT_MIN;
    bit_max       = RST_BIT_MAX;
    one_threshold = RST_ONE_THRESHOLD;
    rx_phase      = RX_STOPPED;
    frame         = '0;
    bit_count     = '0;
    carried       = '0;
    last_status   = ST_NOT_STARTED;
    last_hum      = '0;
    last_temp     = '0;
  endfunction

  function automatic reading_t make_reading(status_t st, logic done);
    reading_t r;
    r.status      = st;
    r.done        = done;
    r.humidity    = (st == ST_OK) ? last_hum : '0;
    r.temperature = (st == ST_OK) ? last_temp : '0;
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(int k);
    return frame[8 * (FRAME_BYTES - 1 - k) +: 8];
  endfunction

  function automatic reading_t end_acquisition(status_t st, rx_phase_t nxt);
    rx_phase    = nxt;
    carried     = '0;
    last_status = st;
    return make_reading(st, 1'b1);
  endfunction

  function automatic reading_t frame_decode_step(cmd_t cmd, logic [US_W-1:0] elapsed);
    logic [US_W:0] delta;
    logic [7:0]    sum;
    logic [7:0]    b0, b1, b2, b3;
    logic          idle;
    idle = (rx_phase == RX_STOPPED) || (rx_phase == RX_ACQUIRED);
    if (cmd == CMD_START) begin
      if (!idle) return make_reading(ST_BUSY, 1'b0);
      rx_phase  = RX_RESPONSE;
      frame     = '0;
      bit_count = '0;
      carried   = '0;
      return make_reading(ST_ACQUIRING, 1'b0);
    end
    if (idle) return make_reading(last_status, 1'b0);

    delta   = carried + elapsed;
    carried = '0;
    if (delta > edge_timeout) return end_acquisition(ST_TIMEOUT, RX_STOPPED);

    if (rx_phase == RX_RESPONSE) begin
      if (delta < preamble_max) begin
        carried = delta;
        return make_reading(ST_ACQUIRING, 1'b0);
      end
      if (response_min < delta && delta < response_max) begin
        rx_phase = RX_DATA;
        return make_reading(ST_ACQUIRING, 1'b0);
      end
      return end_acquisition(ST_RESP_ERR, RX_STOPPED);
    end

    if (bit_min < delta && delta < bit_max) begin
      frame     = {frame[FRAME_W-2:0], (delta > one_threshold)};
      bit_count = bit_count + 1'b1;
      if (bit_count < FRAME_W) return make_reading(ST_ACQUIRING, 1'b0);
      b0  = frame_byte(0);
      b1  = frame_byte(1);
      b2  = frame_byte(2);
      b3  = frame_byte(3);
      sum = b0 + b1 + b2 + b3;
      if (sum != frame_byte(4)) return end_acquisition(ST_CHECKSUM, RX_STOPPED);
      if (!sensor_type) begin
        last_hum  = READ_W'(b0 * 10);
        last_temp = READ_W'(b2 * 10);
      end else begin
        last_hum  = {b0, b1};
        last_temp = b2[7] ? READ_W'(0 - {1'b0, b2[6:0], b3}) : {b2, b3};
      end
      return end_acquisition(ST_OK, RX_ACQUIRED);
    end
    if (delta < GLITCH_US) return end_acquisition(ST_GLITCH, RX_STOPPED);
    return end_acquisition(ST_DATA_ERR, RX_STOPPED);
  endfunction

  task automatic report_mismatch(string what, int got, int want_v);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      reset_receiver_model();
      expected_readings.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unrequested result, status", int'(out_ch.status), -1);
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          if (out_ch.done_res !== want.done)
            report_mismatch("done_res", int'(out_ch.done_res), int'(want.done));
          if (out_ch.humidity_tenths !== want.humidity)
            report_mismatch("humidity_tenths", int'(out_ch.humidity_tenths),
                            int'(want.humidity));
          if (out_ch.temperature_tenths !== want.temperature)
            report_mismatch("temperature_tenths", int'(out_ch.temperature_tenths),
                            int'(want.temperature));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_readings.push_back(frame_decode_step(cmd_t'(in_ch.command),
                                                      in_ch.elapsed_us));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SENSOR_TYPE:   sensor_type   = cfg_data[0];
          REG_EDGE_TIMEOUT:  edge_timeout  = cfg_data[US_W-1:0];
          REG_PREAMBLE_MAX:  preamble_max  = cfg_data[WIN_W-1:0];
          REG_RESPONSE_MIN:  response_min  = cfg_data[WIN_W-1:0];
          REG_RESPONSE_MAX:  response_max  = cfg_data[WIN_W-1:0];
          REG_BIT_MIN:       bit_min       = cfg_data[WIN_W-1:0];
          REG_BIT_MAX:       bit_max       = cfg_data[WIN_W-1:0];
          REG_ONE_THRESHOLD: one_threshold = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
    end
    readings_due = expected_readings.size();
  end

endmodule

[test/dht_edge_timing_receiver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_edge_timing_receiver_tb: testbench of the sensor frame receiver
// Drives starts and edge timings through several register settings: short
// directed cases, then sensor frames with random content, well-formed or
// broken, mixed with noise, under random idling on both channels and long
// result hold-offs. The checker beside the block gives the verdict.
// ----------------------------------------------------------------------------
module dht_edge_timing_receiver_tb;
  import dhtr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    FLAW_NONE, FLAW_CHECKSUM, FLAW_RESPONSE, FLAW_GLITCH, FLAW_DATA,
    FLAW_TIMEOUT, FLAW_RESTART, FLAW_TRUNCATE, FLAW_RETYPE
  } frame_flaw_t;

  typedef struct {
    bit sensor;
    int timeout;
    int pre;
    int rmin;
    int rmax;
    int bmin;
    int bmax;
    int thr;
    int items;
  } setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dhtr_in_if  in_ch ();
  dhtr_out_if out_ch ();

  int mismatches;
  int readings_due;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_requests = 0;
  int holds_served = 0;
  bit quiet = 1'b0;

  bit cur_sensor  = RST_SENSOR_TYPE;
  int cur_timeout = int'(RST_EDGE_TIMEOUT);
  int cur_pre     = int'(RST_PREAMBLE_MAX);
  int cur_rmin    = int'(RST_RESPONSE_MIN);
  int cur_rmax    = int'(RST_RESPONSE_MAX);
  int cur_bmin    = int'(RST_BIT_MIN);
  int cur_bmax    = int'(RST_BIT_MAX);
  int cur_thr     = int'(RST_ONE_THRESHOLD);

  dht_edge_timing_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dhtr_reading_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .readings_due (readings_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_ch.ready <= quiet || ($urandom_range(99, 0) >= 8);
      end
    end
  end

  task automatic send_item(cmd_t c, logic [US_W-1:0] e);
    while (!quiet && $urandom_range(99, 0) < 8) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c;
    in_ch.elapsed_us <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (readings_due != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(v);
    case (idx)
      REG_SENSOR_TYPE:   cur_sensor  = v[0];
      REG_EDGE_TIMEOUT:  cur_timeout = v;
      REG_PREAMBLE_MAX:  cur_pre     = v;
      REG_RESPONSE_MIN:  cur_rmin    = v;
      REG_RESPONSE_MAX:  cur_rmax    = v;
      REG_BIT_MIN:       cur_bmin    = v;
      REG_BIT_MAX:       cur_bmax    = v;
      REG_ONE_THRESHOLD: cur_thr     = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic int pick_open(int lo, int hi);
    if (hi - lo >= 2) return $urandom_range(hi - 1, lo + 1);
    return lo + 1;
  endfunction

  function automatic int noise_elapsed();
    if ($urandom_range(1, 0)) return $urandom_range(65535, 0);
    return $urandom_range(300, 0);
  endfunction

  task automatic send_frame(frame_flaw_t flaw);
    logic [7:0]         b0, b1, b2, b3, chk;
    logic [FRAME_W-1:0] bits;
    int                 carried, e, cut, i, k;
    b0  = 8'($urandom);
    b1  = 8'($urandom);
    b2  = 8'($urandom);
    b3  = 8'($urandom);
    chk = b0 + b1 + b2 + b3;
    if (flaw == FLAW_CHECKSUM) chk = chk ^ 8'($urandom_range(255, 1));
    bits = {b0, b1, b2, b3, chk};
    cut  = $urandom_range(FRAME_W - 1, 0);

    send_item(CMD_START, US_W'($urandom));
    carried = 0;
    for (k = $urandom_range(3, 0); k > 0; k--) begin
      if (cur_pre - carried > 1) begin
        e = $urandom_range(cur_pre - 1 - carried, 0);
        carried += e;
        send_item(CMD_EDGE, US_W'(e));
      end
    end
    if (flaw == FLAW_RESPONSE) begin
      send_item(CMD_EDGE, US_W'(cur_rmax + $urandom_range(40, 0)));
      return;
    end
    e = pick_open(cur_rmin, cur_rmax) - carried;
    send_item(CMD_EDGE, US_W'((e < 0) ? 0 : e));

    for (i = 0; i < FRAME_W; i++) begin
      if (i == cut) begin
        case (flaw)
          FLAW_GLITCH:  send_item(CMD_EDGE, US_W'($urandom_range(GLITCH_US - 1, 0)));
          FLAW_DATA:    send_item(CMD_EDGE, US_W'(cur_bmax + $urandom_range(200, 0)));
          FLAW_TIMEOUT: begin
            e = cur_timeout + 1 + $urandom_range(100, 0);
            send_item(CMD_EDGE, US_W'((e > 65535) ? 65535 : e));
          end
          FLAW_RESTART: send_item(CMD_START, US_W'($urandom));
          FLAW_RETYPE: begin
            drain();
            write_reg(REG_SENSOR_TYPE, int'(!cur_sensor));
            cfg_we <= 1'b0;
          end
          default: ;
        endcase
        if (flaw inside {FLAW_GLITCH, FLAW_DATA, FLAW_TIMEOUT, FLAW_TRUNCATE}) return;
      end
      if (bits[FRAME_W-1-i])
        e = pick_open((cur_bmin > cur_thr) ? cur_bmin : cur_thr, cur_bmax);
      else
        e = pick_open(cur_bmin, (cur_thr + 1 < cur_bmax) ? cur_thr + 1 : cur_bmax);
      send_item(CMD_EDGE, US_W'(e));
    end
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(REG_SENSOR_TYPE, int'(s.sensor));
    write_reg(REG_EDGE_TIMEOUT, s.timeout);
    write_reg(REG_PREAMBLE_MAX, s.pre);
    write_reg(REG_RESPONSE_MIN, s.rmin);
    write_reg(REG_RESPONSE_MAX, s.rmax);
    write_reg(REG_BIT_MIN, s.bmin);
    write_reg(REG_BIT_MAX, s.bmax);
    write_reg(REG_ONE_THRESHOLD, s.thr);
    cfg_we <= 1'b0;
  endtask

  initial begin
    setting_t plan [7];
    int       p, phase_start, r, n;
    bit       held;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_START;
    in_ch.elapsed_us = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_SENSOR_TYPE;
    cfg_data         = '0;
    rst_n            = 1'b0;

    plan[0] = '{1'b1, 6000, 65, 125, 200, 60, 155, 110, 280};
    plan[1] = '{1'b0, 6000, 65, 125, 200, 60, 155, 110, 280};
    plan[2] = '{1'b1, 65535, 1023, 1023, 1023, 1023, 1023, 1023, 110};
    plan[3] = '{1'b0, 0, 0, 0, 0, 0, 0, 0, 110};
    plan[4] = '{1'b0, 65535, 0, 0, 1023, 0, 1023, 500, 280};
    plan[5].sensor  = 1'($urandom_range(1, 0));
    plan[5].timeout = $urandom_range(20000, 300);
    plan[5].pre     = $urandom_range(60, 5);
    plan[5].rmin    = plan[5].pre + $urandom_range(50, 0);
    plan[5].rmax    = plan[5].rmin + $urandom_range(80, 2);
    plan[5].bmin    = $urandom_range(80, 10);
    plan[5].bmax    = plan[5].bmin + $urandom_range(120, 4);
    plan[5].thr     = pick_open(plan[5].bmin, plan[5].bmax);
    plan[5].items   = 280;
    plan[6] = '{1'b1, 200, 20, 40, 43, 10, 13, 11, 280};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // not started, start, refused start, carried preamble, glitch
    send_item(CMD_EDGE, 16'd0);
    send_item(CMD_EDGE, 16'hFFFF);
    send_item(CMD_START, 16'hFFFF);
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd30);
    send_item(CMD_EDGE, 16'd120);
    send_item(CMD_EDGE, 16'd5);
    send_item(CMD_EDGE, 16'd77);
    // timeout, response at the timeout bound, data error
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd6001);
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd6000);
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd150);
    send_item(CMD_EDGE, 16'd200);
    // window bounds are exclusive
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd64);
    send_item(CMD_EDGE, 16'd64);
    send_item(CMD_EDGE, 16'd155);
    send_item(CMD_START, 16'd0);
    send_item(CMD_EDGE, 16'd125);
    send_item(CMD_EDGE, 16'd0);

    for (p = 0; p < 7; p++) begin
      if (p > 0) begin
        drain();
        apply_setting(plan[p]);
      end
      if (p == 2) begin
        // carry past the 16-bit range into a timeout
        send_item(CMD_START, 16'd0);
        send_item(CMD_EDGE, 16'd1000);
        send_item(CMD_EDGE, 16'hFFFF);
      end
      quiet       = (p == 4);
      phase_start = items_sent;
      held        = 1'b0;
      while (items_sent - phase_start < plan[p].items) begin
        if (!held && items_sent - phase_start > plan[p].items / 2) begin
          held = 1'b1;
          if (p == 1 || p == 5) hold_requests++;
          if (p == 0) drain();
        end
        if ($urandom_range(99, 0) < 70) begin
          r = $urandom_range(14, 0);
          send_frame((r < 7) ? FLAW_NONE : frame_flaw_t'(r - 6));
        end else begin
          for (n = $urandom_range(5, 1); n > 0; n--)
            send_item(cmd_t'($urandom_range(1, 0)), US_W'(noise_elapsed()));
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/core/dhtr_pkg.sv
rtl/core/dhtr_if.sv
rtl/core/dht_edge_timing_receiver.sv
test/dht_edge_timing_receiver_checker.sv
test/dht_edge_timing_receiver_tb.sv
